[hw/rtl/kf3_pkg.sv]
// ----------------------------------------------------------------------------
// kf3_pkg: shared types and constants for the three-state Kalman filter
// Payload structs, operation codes of the shared unit and the sequencer states.
// ----------------------------------------------------------------------------
package kf3_pkg;

  localparam int FracBitsDefault = 16;
  localparam logic [30:0] QReset = 31'd6554;
  localparam logic [30:0] RReset = 31'd65536;

  localparam logic signed [31:0] Max32 = 32'sh7fffffff;
  localparam logic signed [31:0] Min32 = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] control_acceleration;
    logic signed [31:0] meas_altitude;
    logic signed [31:0] meas_velocity;
    logic signed [31:0] meas_acceleration;
  } kf3_in_t;

  typedef struct packed {
    logic signed [31:0] est_altitude;
    logic signed [31:0] est_velocity;
    logic signed [31:0] est_acceleration;
  } kf3_out_t;

  typedef enum logic [0:0] {
    CFG_Q = 1'b0,
    CFG_R = 1'b1
  } cfg_idx_t;

  // sequencer phases
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,     // x' and P'
    ST_COF,      // cofactors of S
    ST_DET,      // det(S)
    ST_MAT,      // P' adj(S)
    ST_DIV,      // K = M / det
    ST_DIVW,
    ST_INNOV,    // y and K y
    ST_KP,       // K P'
    ST_DONE
  } kf3_state_t;

  // requests to the shared multiply-accumulate unit
  typedef struct packed {
    logic               clr;   // start accumulator at zero
    logic               en;    // add a*b (rounded) to the accumulator
    logic               neg;   // subtract instead of add
    logic signed [31:0] a;
    logic signed [31:0] b;
  } kf3_mac_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return Max32;
    if (v < -64'sd2147483648) return Min32;
    return v[31:0];
  endfunction

endpackage

[hw/rtl/kf3_mac.sv]
// ----------------------------------------------------------------------------
// kf3_mac: shared fixed-point multiply-accumulate unit
// One 32x32 product a cycle, registered, rounded and added to a wide sum.
// ----------------------------------------------------------------------------
module kf3_mac import kf3_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  kf3_mac_req_t       req,
  output logic signed [63:0] acc
);

  logic signed [63:0] prod_r;
  logic               prod_en_r, prod_neg_r, prod_clr_r;
  logic signed [63:0] acc_r, acc_nxt, rnd;

  // product round half up, floor shift
  assign rnd = (prod_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_comb begin
    acc_nxt = prod_clr_r ? 64'sd0 : acc_r;
    if (prod_en_r) begin
      acc_nxt = prod_neg_r ? acc_nxt - rnd : acc_nxt + rnd;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= 64'(req.a) * 64'(req.b);
    prod_en_r  <= req.en;
    prod_neg_r <= req.neg;
    prod_clr_r <= req.clr;
    acc_r      <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

[hw/rtl/kf3_div.sv]
// ----------------------------------------------------------------------------
// kf3_div: radix-2 restoring divider
// Computes sat32((num << FRAC_BITS) / den), truncating toward zero.
// ----------------------------------------------------------------------------
module kf3_div import kf3_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   dv_r;
  logic          neg_r, busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [33:0]   trial;
  logic [NW:0]   qmag;
  logic [31:0]   nmag;

  assign nmag  = num[31] ? 32'(-num) : 32'(num);
  assign trial = {rem_r, q_r[NW-1]} - {2'b0, dv_r};

  always_comb begin
    q_nxt   = {q_r[NW-2:0], 1'b0};
    rem_nxt = {rem_r[31:0], q_r[NW-1]};
    if (!trial[33]) begin
      rem_nxt = trial[32:0];
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        q_r    <= NW'({nmag, FRAC_BITS'(0)});
        rem_r  <= '0;
        dv_r   <= den[31] ? 32'(-den) : 32'(den);
        neg_r  <= num[31] ^ den[31];
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign qmag = {1'b0, q_r};
  always_comb begin
    if (neg_r) begin
      quo = (qmag > (NW+1)'(33'h80000000)) ? Min32 : 32'(-qmag);
    end else begin
      quo = (qmag > (NW+1)'(32'h7fffffff)) ? Max32 : qmag[31:0];
    end
  end
  assign done = done_r;

endmodule

[hw/rtl/kalman_filter_3state.sv]
// ----------------------------------------------------------------------------
// kalman_filter_3state: three-state linear Kalman filter, Q16.16
// Sequencer around one shared multiply-accumulate unit and one divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries control acceleration
//   and three measurements. Output channel (out_valid/out_stall/out_data)
//   returns the corrected altitude, velocity and acceleration estimate.
//   cfg_we/cfg_index/cfg_wdata write process noise (0) and measurement
//   noise (1); write only while idle.
// Work: set by the single MAC (cofactors, det, P'adj, K y, K P': 84 products)
//   and nine serial divisions of 32+FRAC_BITS steps each.
// Flow: one item at a time; in_stall is high while the sequencer is busy, so
//   a new item is taken only once the last one has left the sequencer.
// Reset: state estimate and covariance clear, noise registers take their
//   defaults, no result pending.
// Stall: the result is held in an output register until the transfer; the
//   next item may be accepted meanwhile, and if its result is ready first
//   the sequencer waits in its last step.
// ----------------------------------------------------------------------------
module kalman_filter_3state import kf3_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  kf3_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output kf3_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_wdata
);

  kf3_state_t st_r, st_nxt;

  logic [30:0]        q_r, r_r;
  logic signed [31:0] x_r [3];
  logic signed [31:0] p_r [9];
  logic signed [31:0] xp_r [3];
  logic signed [31:0] pp_r [9];
  logic signed [31:0] adj_r [9];
  logic signed [31:0] m_r [9];
  logic signed [31:0] k_r [9];
  logic signed [31:0] y_r [3];
  logic signed [31:0] z_r [3];
  logic signed [31:0] u_r;
  logic signed [31:0] det_r;
  kf3_out_t           out_r;
  logic               out_valid_r;
  logic               out_load;  // result moves into the output register

  // step counter: term index within an entry and entry index
  logic [1:0] t_r;      // term 0..nterm-1 issue, nterm = capture wait
  logic [3:0] e_r;      // entry 0..8
  logic [1:0] w_r;      // pipeline drain count

  kf3_mac_req_t       req;
  logic signed [63:0] acc;
  logic               div_start, div_done;
  logic signed [31:0] quo;

  kf3_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (.clk(clk), .req(req), .acc(acc));
  kf3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(m_r[e_r]), .den(det_r),
    .done(div_done), .quo(quo)
  );

  // S entry: P' plus r on the diagonal, saturated
  function automatic logic signed [31:0] s_at(input logic [1:0] i, input logic [1:0] j,
      input logic signed [31:0] pv, input logic [30:0] rv);
    if (i == j) return sat32(64'(pv) + 64'($signed({1'b0, rv})));
    return pv;
  endfunction

  function automatic logic [1:0] m3(input logic [2:0] v);
    return (v >= 3'd3) ? 2'(v - 3'd3) : v[1:0];
  endfunction

  logic [1:0] ei, ej, i1, i2, j1, j2;
  logic [3:0] ia, ib, ic, id;
  logic       issue;    // a term is issued to the MAC
  logic [1:0] nterm;

  always_comb begin
    // row and column of the entry
    ei = (e_r >= 4'd6) ? 2'd2 : ((e_r >= 4'd3) ? 2'd1 : 2'd0);
    ej = 2'(e_r - 4'(ei) * 4'd3);
    i1 = m3({1'b0, ei} + 3'd1);
    i2 = m3({1'b0, ei} + 3'd2);
    j1 = m3({1'b0, ej} + 3'd1);
    j2 = m3({1'b0, ej} + 3'd2);
    ia = 4'(i1 * 3 + j1);
    ib = 4'(i2 * 3 + j2);
    ic = 4'(i1 * 3 + j2);
    id = 4'(i2 * 3 + j1);
  end

  always_comb begin
    req = '0;
    nterm = 2'd3;
    unique case (st_r)
      ST_COF: begin
        nterm = 2'd2;
        if (t_r == 2'd0) begin
          req.a = s_at(i1, j1, pp_r[ia], r_r);
          req.b = s_at(i2, j2, pp_r[ib], r_r);
        end else begin
          req.a = s_at(i1, j2, pp_r[ic], r_r);
          req.b = s_at(i2, j1, pp_r[id], r_r);
          req.neg = 1'b1;
        end
      end
      ST_DET: begin
        req.a = s_at(2'd0, t_r, pp_r[4'(t_r)], r_r);
        req.b = adj_r[4'(t_r) * 4'd3];
      end
      ST_MAT: begin
        req.a = pp_r[4'(ei * 3 + t_r)];
        req.b = adj_r[4'(t_r * 3 + ej)];
      end
      ST_INNOV: begin
        req.a = k_r[4'(e_r[1:0] * 3 + t_r)];
        req.b = sat32(64'(z_r[t_r]) - 64'(xp_r[t_r]));
      end
      ST_KP: begin
        req.a = k_r[4'(ei * 3 + t_r)];
        req.b = pp_r[4'(t_r * 3 + ej)];
      end
      default: ;
    endcase
    issue = (t_r < nterm) && (st_r == ST_COF || st_r == ST_DET || st_r == ST_MAT ||
             st_r == ST_INNOV || st_r == ST_KP);
    req.en  = issue;
    req.clr = issue && (t_r == 2'd0);
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign div_start = (st_r == ST_DIV);
  assign out_load  = (st_r == ST_DONE) && (!out_valid_r || !out_stall);

  // index of the last entry per phase
  logic [3:0] last_e;
  logic       entry_end;
  always_comb begin
    last_e = (st_r == ST_DET || st_r == ST_INNOV) ? 4'd0 : 4'd8;
    if (st_r == ST_INNOV) last_e = 4'd2;
    entry_end = (t_r == nterm) && (w_r == 2'd1);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_valid && !in_stall) st_nxt = ST_PRED;
      ST_PRED:  st_nxt = ST_COF;
      ST_COF:   if (entry_end && e_r == last_e) st_nxt = ST_DET;
      ST_DET:   if (entry_end) st_nxt = ST_MAT;
      ST_MAT:   if (entry_end && e_r == last_e) st_nxt = ST_DIV;
      ST_DIV:   st_nxt = ST_DIVW;
      ST_DIVW:  if (div_done) st_nxt = (e_r == 4'd8) ? ST_INNOV : ST_DIV;
      ST_INNOV: if (entry_end && e_r == last_e) st_nxt = ST_KP;
      ST_KP:    if (entry_end && e_r == last_e) st_nxt = ST_DONE;
      ST_DONE:  if (out_load) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  logic signed [31:0] accs;
  assign accs = sat32(acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= QReset;
      r_r <= RReset;
      out_valid_r <= 1'b0;
      t_r <= '0;
      e_r <= '0;
      w_r <= '0;
      for (int i = 0; i < 3; i++) x_r[i] <= '0;
      for (int i = 0; i < 9; i++) p_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_Q) q_r <= cfg_wdata;
        else r_r <= cfg_wdata;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      // term / drain / entry stepping for MAC phases
      if (issue) begin
        t_r <= t_r + 1'b1;
        w_r <= 2'd2;
      end else if (w_r != 2'd0) begin
        w_r <= w_r - 1'b1;
      end
      if (entry_end) begin
        t_r <= '0;
        w_r <= '0;
        e_r <= (e_r == last_e) ? 4'd0 : e_r + 1'b1;
        unique case (st_r)
          ST_COF: adj_r[4'(ej * 3 + ei)] <= accs;
          ST_DET: det_r <= accs;
          ST_MAT: m_r[e_r] <= accs;
          ST_INNOV: x_r[e_r[1:0]] <= sat32(64'(xp_r[e_r[1:0]]) + 64'(accs));
          ST_KP: p_r[e_r] <= sat32(64'(pp_r[e_r]) - 64'(accs));
          default: ;
        endcase
      end

      unique case (st_r)
        ST_IDLE: if (in_valid && !in_stall) begin
          u_r    <= in_data.control_acceleration;
          z_r[0] <= in_data.meas_altitude;
          z_r[1] <= in_data.meas_velocity;
          z_r[2] <= in_data.meas_acceleration;
          t_r <= '0;
          e_r <= '0;
          w_r <= '0;
        end
        ST_PRED: begin
          xp_r[0] <= sat32(64'(x_r[0]) + 64'(x_r[1]) + 64'(x_r[2]));
          xp_r[1] <= sat32(64'(x_r[1]) + 64'(x_r[2]));
          xp_r[2] <= sat32(64'(x_r[2]) + 64'(u_r));
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              logic signed [63:0] s;
              s = 64'sd0;
              for (int a = i; a < 3; a++)
                for (int b = j; b < 3; b++) s = s + 64'(p_r[a*3+b]);
              if (i == j) s = s + 64'($signed({1'b0, q_r}));
              pp_r[i*3+j] <= sat32(s);
            end
          end
        end
        ST_DIVW: if (div_done) begin
          k_r[e_r] <= (det_r == 32'sd0) ? 32'sd0 : quo;
          e_r <= (e_r == 4'd8) ? 4'd0 : e_r + 1'b1;
        end
        ST_DONE: if (out_load) begin
          out_r.est_altitude     <= x_r[0];
          out_r.est_velocity     <= x_r[1];
          out_r.est_acceleration <= x_r[2];
        end
        default: ;
      endcase
    end
  end

endmodule
